// ===== rtl/cmr_pkg.sv =====
// ----------------------------------------------------------------------------
// cmr_pkg
// shared widths, constants and register codes for the colour mode converter
// ----------------------------------------------------------------------------
package cmr_pkg;

  localparam int VAL_W     = 16;  // signed user value
  localparam int MAX_W     = 15;  // full-scale register
  localparam int FRAC_W    = 17;  // unsigned q1.16 fraction, 65536 is one
  localparam int BYTE_W    = 8;
  localparam int DIV_STEPS = FRAC_W;  // one quotient bit per cell
  localparam int ADDR_W    = 5;

  localparam logic [FRAC_W-1:0] FRAC_ONE  = 17'd65536;
  localparam logic [FRAC_W-1:0] THIRD_ONE = 17'd21845;
  localparam logic [FRAC_W-1:0] THIRD_TWO = 17'd43690;
  localparam logic [MAX_W-1:0]  SIXTH     = 15'd10922;
  localparam logic [MAX_W-1:0]  MAX_RESET = 15'd255;

  // 65536 = 6 * sixth + 4, so below one sixth x * 65536 / sixth is 6x plus
  // one for each of these numerators reached
  localparam logic [FRAC_W-1:0] RAMP_STEP_A = 17'd2731;
  localparam logic [FRAC_W-1:0] RAMP_STEP_B = 17'd5461;
  localparam logic [FRAC_W-1:0] RAMP_STEP_C = 17'd8192;

  typedef enum logic [2:0] {
    REG_MODE        = 3'd0,
    REG_MAX_FIRST   = 3'd1,
    REG_MAX_SECOND  = 3'd2,
    REG_MAX_THIRD   = 3'd3,
    REG_MAX_OPACITY = 3'd4
  } reg_idx_t;

  // fraction times 255 over 65536, truncated
  function automatic logic [BYTE_W-1:0] frac_to_byte(input logic [FRAC_W-1:0] f);
    logic [FRAC_W+BYTE_W-1:0] p;
    p = {f, 8'd0} - {8'd0, f};
    frac_to_byte = (p[FRAC_W+BYTE_W-1:16] > 9'd255) ? 8'd255 : p[23:16];
  endfunction

endpackage

// ===== rtl/cmr_div_cell.sv =====
// ----------------------------------------------------------------------------
// cmr_div_cell
// one restoring division step, produces one quotient bit per cycle while en is high
// ----------------------------------------------------------------------------
module cmr_div_cell
  import cmr_pkg::*;
#(
  parameter bit FIRST = 1'b0
) (
  input  logic              clk,
  input  logic              en,
  input  logic [MAX_W-1:0]  divisor,
  input  logic [MAX_W-1:0]  rem_in,
  input  logic [FRAC_W-1:0] quot_in,
  output logic [MAX_W-1:0]  rem_out,
  output logic [FRAC_W-1:0] quot_out
);

  logic [MAX_W:0]    cand;
  logic [MAX_W:0]    diff;
  logic              q_bit;
  logic [MAX_W-1:0]  rem_r, rem_nxt;
  logic [FRAC_W-1:0] quot_r, quot_nxt;

  always_comb begin
    // first step compares the dividend as is, later ones shift in a zero
    cand     = FIRST ? {1'b0, rem_in} : {rem_in, 1'b0};
    diff     = cand - {1'b0, divisor};
    q_bit    = (cand >= {1'b0, divisor});
    rem_nxt  = q_bit ? diff[MAX_W-1:0] : cand[MAX_W-1:0];
    quot_nxt = {quot_in[FRAC_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      quot_r <= quot_nxt;
    end
  end

  assign rem_out  = rem_r;
  assign quot_out = quot_r;

endmodule

// ===== rtl/cmr_div_row.sv =====
// ----------------------------------------------------------------------------
// cmr_div_row
// row of division cells, floor(dividend * 65536 / divisor) for dividend <= divisor
// ----------------------------------------------------------------------------
module cmr_div_row
  import cmr_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [MAX_W-1:0]  divisor,
  input  logic [MAX_W-1:0]  dividend,
  output logic [FRAC_W-1:0] quot
);

  logic [MAX_W-1:0]  rem_w  [DIV_STEPS+1];
  logic [FRAC_W-1:0] quot_w [DIV_STEPS+1];

  assign rem_w[0]  = dividend;
  assign quot_w[0] = '0;

  for (genvar i = 0; i < DIV_STEPS; i++) begin : g_cell
    cmr_div_cell #(.FIRST(i == 0)) u_cell (
      .clk     (clk),
      .en      (en),
      .divisor (divisor),
      .rem_in  (rem_w[i]),
      .quot_in (quot_w[i]),
      .rem_out (rem_w[i+1]),
      .quot_out(quot_w[i+1])
    );
  end

  assign quot = quot_w[DIV_STEPS];

endmodule

// ===== rtl/color_mode_to_rgba8.sv =====
// ----------------------------------------------------------------------------
// color_mode_to_rgba8
// rgb or hue/saturation/brightness colour in user units to four 8-bit bytes
// ----------------------------------------------------------------------------
// a word passes the clamp, division cell, ramp, s*t, m, m*b and byte registers
// throughput: one word per cycle unless stalled, each cell and stage holds one word
// a one-word skid register takes a result while the output side stalls,
// and the whole pipeline and the input hold until it empties
// rst_n (synchronous) clears stage valids and skid, mode to rgb, maxima to 255
// ----------------------------------------------------------------------------
module color_mode_to_rgba8
  import cmr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // value_one [15:0], value_two [31:16], value_three [47:32], opacity_in [63:48]
  input  logic [63:0]       in_tdata,
  input  logic              in_tvalid,
  output logic              in_tready,
  // red_out [7:0], green_out [15:8], blue_out [23:16], opacity_out [31:24]
  output logic [31:0]       out_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [31:0]       cfg_pwdata,
  output logic [31:0]       cfg_prdata,
  output logic              cfg_pready
);

  localparam int NCH     = 4;
  localparam int NRAMP   = 3;
  // clamp, division cells, ramps, s*t, m, m*b, bytes
  localparam int NSTAGE  = DIV_STEPS + 6;

  typedef struct packed {
    logic [NCH-1:0][BYTE_W-1:0] bytes;  // rgb-mode bytes, alpha last
    logic [FRAC_W-1:0]          sfrac;
    logic [FRAC_W-1:0]          bfrac;
  } side_t;

  // --------------------------------------------------------------------------
  // configuration registers
  // --------------------------------------------------------------------------
  logic             mode_r;
  logic [MAX_W-1:0] max_r [NCH];
  logic             cfg_wr;
  reg_idx_t         cfg_idx;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_idx    = reg_idx_t'(cfg_paddr[ADDR_W-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= 1'b0;
      for (int i = 0; i < NCH; i++) max_r[i] <= MAX_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:        mode_r   <= cfg_pwdata[0];
        REG_MAX_FIRST:   max_r[0] <= cfg_pwdata[MAX_W-1:0];
        REG_MAX_SECOND:  max_r[1] <= cfg_pwdata[MAX_W-1:0];
        REG_MAX_THIRD:   max_r[2] <= cfg_pwdata[MAX_W-1:0];
        REG_MAX_OPACITY: max_r[3] <= cfg_pwdata[MAX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:        cfg_prdata = {31'd0, mode_r};
      REG_MAX_FIRST:   cfg_prdata = {17'd0, max_r[0]};
      REG_MAX_SECOND:  cfg_prdata = {17'd0, max_r[1]};
      REG_MAX_THIRD:   cfg_prdata = {17'd0, max_r[2]};
      REG_MAX_OPACITY: cfg_prdata = {17'd0, max_r[3]};
      default:         cfg_prdata = '0;
    endcase
  end

  // a zero full scale behaves as one
  logic [MAX_W-1:0] max_eff [NCH];
  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      max_eff[i] = (max_r[i] == '0) ? MAX_W'(1) : max_r[i];
    end
  end

  // --------------------------------------------------------------------------
  // pipeline control: every stage moves while the skid register is empty
  // --------------------------------------------------------------------------
  logic              skid_full_r;
  logic              en;
  logic              in_acc;
  logic [NSTAGE-1:0] vld_r;

  assign en        = ~skid_full_r;
  assign in_tready = en;
  assign in_acc    = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_acc};
    end
  end

  // --------------------------------------------------------------------------
  // stage 0: clamp each value to zero and its full scale
  // --------------------------------------------------------------------------
  logic [MAX_W-1:0] clamp_r [NCH];
  logic [MAX_W-1:0] clamp_nxt [NCH];

  always_comb begin
    for (int i = 0; i < NCH; i++) begin
      logic signed [VAL_W-1:0] v;
      v = in_tdata[i*VAL_W +: VAL_W];
      if (v[VAL_W-1])
        clamp_nxt[i] = '0;
      else if (v[MAX_W-1:0] > max_eff[i])
        clamp_nxt[i] = max_eff[i];
      else
        clamp_nxt[i] = v[MAX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) clamp_r <= clamp_nxt;
  end

  // normalise to q1.16 fractions
  logic [FRAC_W-1:0] frac [NCH];

  for (genvar i = 0; i < NCH; i++) begin : g_norm
    cmr_div_row u_norm (
      .clk     (clk),
      .en      (en),
      .divisor (max_eff[i]),
      .dividend(clamp_r[i]),
      .quot    (frac[i])
    );
  end

  // --------------------------------------------------------------------------
  // stage 1: rgb bytes and the three hue ramps
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0] xr, xg, xb;
  logic [FRAC_W-1:0] t_r [NRAMP];
  logic [FRAC_W-1:0] t_nxt [NRAMP];
  side_t             side_r, side_nxt;

  always_comb begin
    logic [FRAC_W-1:0] x [NRAMP];
    logic [1:0]        step;
    if (frac[0] < THIRD_ONE) begin
      xr = THIRD_ONE - frac[0];
      xg = frac[0];
      xb = '0;
    end else if (frac[0] < THIRD_TWO) begin
      xr = '0;
      xg = THIRD_TWO - frac[0];
      xb = frac[0] - THIRD_ONE;
    end else begin
      xr = frac[0] - THIRD_TWO;
      xg = '0;
      xb = FRAC_ONE - frac[0];
    end
    x[0] = xr;
    x[1] = xg;
    x[2] = xb;
    for (int i = 0; i < NRAMP; i++) begin
      // a numerator of one sixth or more saturates the ramp at one,
      // below that the ramp is 6x plus a small step count
      step = 2'(x[i] >= RAMP_STEP_A) + 2'(x[i] >= RAMP_STEP_B)
           + 2'(x[i] >= RAMP_STEP_C);
      if (x[i] >= {2'd0, SIXTH})
        t_nxt[i] = FRAC_ONE;
      else
        t_nxt[i] = (x[i] << 2) + (x[i] << 1) + FRAC_W'(step);
    end
    for (int i = 0; i < NCH; i++) side_nxt.bytes[i] = frac_to_byte(frac[i]);
    side_nxt.sfrac = frac[1];
    side_nxt.bfrac = frac[2];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r    <= t_nxt;
      side_r <= side_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: s * t
  // --------------------------------------------------------------------------
  logic [2*FRAC_W-1:0]        st_r [NRAMP];
  logic [2*FRAC_W-1:0]        st_nxt [NRAMP];
  logic [FRAC_W-1:0]          s2_s_r, s2_b_r;
  logic [NCH-1:0][BYTE_W-1:0] s2_bytes_r;

  always_comb begin
    for (int i = 0; i < NRAMP; i++) begin
      st_nxt[i] = side_r.sfrac * t_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      st_r       <= st_nxt;
      s2_s_r     <= side_r.sfrac;
      s2_b_r     <= side_r.bfrac;
      s2_bytes_r <= side_r.bytes;
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: m = 1 - s + s*t
  // --------------------------------------------------------------------------
  logic [FRAC_W-1:0]          m_r [NRAMP];
  logic [FRAC_W-1:0]          m_nxt [NRAMP];
  logic [FRAC_W-1:0]          s3_b_r;
  logic [NCH-1:0][BYTE_W-1:0] s3_bytes_r;

  always_comb begin
    logic [FRAC_W:0] sum;
    for (int i = 0; i < NRAMP; i++) begin
      // s*t never exceeds one in q2.32, so bits 32 down to 16 hold s*t/65536
      sum      = {1'b0, FRAC_ONE} - {1'b0, s2_s_r}
               + {1'b0, st_r[i][2*FRAC_W-2:16]};
      m_nxt[i] = sum[FRAC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_r        <= m_nxt;
      s3_b_r     <= s2_b_r;
      s3_bytes_r <= s2_bytes_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 4: m * b
  // --------------------------------------------------------------------------
  logic [2*FRAC_W-1:0]        mb_r [NRAMP];
  logic [NCH-1:0][BYTE_W-1:0] s4_bytes_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NRAMP; i++) mb_r[i] <= m_r[i] * s3_b_r;
      s4_bytes_r <= s3_bytes_r;
    end
  end

  // --------------------------------------------------------------------------
  // stage 5: times 255 over 2^32, then pick by mode
  // --------------------------------------------------------------------------
  logic [31:0] res_r, res_nxt;

  always_comb begin
    logic [2*FRAC_W+BYTE_W-1:0] p;
    logic [BYTE_W-1:0]          hsb [NRAMP];
    for (int i = 0; i < NRAMP; i++) begin
      p      = {mb_r[i], 8'd0} - {8'd0, mb_r[i]};
      hsb[i] = (p[2*FRAC_W+BYTE_W-1:32] > 10'd255) ? 8'd255 : p[39:32];
    end
    if (mode_r)
      res_nxt = {s4_bytes_r[3], hsb[2], hsb[1], hsb[0]};
    else
      res_nxt = s4_bytes_r;
  end

  always_ff @(posedge clk) begin
    if (en) res_r <= res_nxt;
  end

  // --------------------------------------------------------------------------
  // skid register: catches the last stage's word when the output stalls
  // --------------------------------------------------------------------------
  logic [31:0] skid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skid_full_r <= 1'b0;
    end else if (skid_full_r) begin
      if (out_tready) skid_full_r <= 1'b0;
    end else if (vld_r[NSTAGE-1] && !out_tready) begin
      skid_full_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!skid_full_r) skid_r <= res_r;
  end

  assign out_tvalid = skid_full_r | vld_r[NSTAGE-1];
  assign out_tdata  = skid_full_r ? skid_r : res_r;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// colour converter testbench
// drives colour words through color_mode_to_rgba8 under several register
// settings and idling phases, predicting each output word and comparing it
// ----------------------------------------------------------------------------
module testbench
  import cmr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // predicted output words, oldest first
  class colour_board;
    logic [31:0] pending_rgba[$];
    int          errors;

    function new();
      errors = 0;
    endfunction

    function void note_input(logic [31:0] rgba);
      pending_rgba.push_back(rgba);
    endfunction

    function void check_output(logic [31:0] got);
      logic [31:0] want;
      if (pending_rgba.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, got);
        errors++;
        return;
      end
      want = pending_rgba.pop_front();
      for (int k = 0; k < 4; k++)
        if (want[8*k +: 8] !== got[8*k +: 8]) begin
          $display("%0t: byte %0d mismatch, expected %0d, actual %0d",
                   $time, k, want[8*k +: 8], got[8*k +: 8]);
          errors++;
        end
    endfunction
  endclass

  logic              clk = 0;
  logic              rst_n = 0;
  logic [63:0]       in_tdata = '0;
  logic              in_tvalid = 0;
  logic              in_tready;
  logic [31:0]       out_tdata;
  logic              out_tvalid;
  logic              out_tready = 0;
  logic              cfg_psel = 0;
  logic              cfg_penable = 0;
  logic              cfg_pwrite = 0;
  logic [ADDR_W-1:0] cfg_paddr = '0;
  logic [31:0]       cfg_pwdata = '0;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;

  color_mode_to_rgba8 uut (.*);

  always begin
    #6 clk = 1;
    #6 clk = 0;
  end

  colour_board board = new();

  // predictor's copy of the registers
  logic        p_hsb;
  logic [14:0] p_max[4];

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int idle_count = 0;

  function automatic logic [16:0] frac_of(logic [15:0] raw, logic [14:0] mx);
    int v;
    longint c, m;
    v = $signed(raw);
    m = (mx == 0) ? 1 : mx;
    if (v < 0) c = 0;
    else if (v > m) c = m;
    else c = v;
    return 17'((c << 16) / m);
  endfunction

  function automatic logic [7:0] byte_of(logic [16:0] f);
    longint r;
    r = (longint'(f) * 255) >> 16;
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  function automatic longint hue_ramp(longint x);
    longint r;
    r = (x << 16) / 10922;
    return (r > 65536) ? 65536 : r;
  endfunction

  function automatic logic [7:0] shade_of(longint s, longint t, longint b);
    longint m, r;
    m = 65536 - s + ((s * t) >> 16);
    r = (m * b * 255) >> 32;
    return (r > 255) ? 8'd255 : 8'(r);
  endfunction

  function automatic logic [31:0] predict_rgba(logic [63:0] d);
    logic [16:0] f[4];
    logic [7:0]  r, g, b;
    longint      h, tr, tg, tb;
    for (int k = 0; k < 4; k++) f[k] = frac_of(d[16*k +: 16], p_max[k]);
    if (!p_hsb) begin
      r = byte_of(f[0]); g = byte_of(f[1]); b = byte_of(f[2]);
    end else begin
      h = f[0];
      // hue thirds pick which ramps rise and fall
      if (h < 21845) begin
        tr = hue_ramp(21845 - h); tg = hue_ramp(h); tb = 0;
      end else if (h < 43690) begin
        tr = 0; tg = hue_ramp(43690 - h); tb = hue_ramp(h - 21845);
      end else begin
        tr = hue_ramp(h - 43690); tg = 0; tb = hue_ramp(65536 - h);
      end
      r = shade_of(f[1], tr, f[2]);
      g = shade_of(f[1], tg, f[2]);
      b = shade_of(f[1], tb, f[2]);
    end
    return {byte_of(f[3]), b, g, r};
  endfunction

  // output side: random stall, check every accepted word
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_output(out_tdata);
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // watchdog on accepted words
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || !rst_n)
      idle_count <= 0;
    else
      idle_count <= idle_count + 1;
    if (idle_count > 20000) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic reg_write(reg_idx_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1; cfg_pwrite <= 1; cfg_penable <= 0;
    cfg_paddr <= ADDR_W'(4 * int'(idx)); cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel <= 0; cfg_penable <= 0; cfg_pwrite <= 0;
    if (idx == REG_MODE) p_hsb = val[0];
    else p_max[int'(idx) - 1] = val[14:0];
  endtask

  task automatic drain();
    while (board.pending_rgba.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic send_word(logic [63:0] d);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata  <= d;
    do @(posedge clk); while (!in_tready);
    board.note_input(predict_rgba(d));
  endtask

  task automatic drop_valid();
    in_tvalid <= 0;
  endtask

  function automatic logic [15:0] rand_value(logic [14:0] mx);
    case ($urandom_range(9))
      0: return 16'($urandom);
      1: return 16'h8000;
      2: return 16'h7fff;
      3: return 16'(mx);
      4: return 16'd0;
      default: return 16'($urandom_range(mx));
    endcase
  endfunction

  task automatic random_batch(int n);
    logic [63:0] d;
    for (int i = 0; i < n; i++) begin
      for (int k = 0; k < 4; k++) d[16*k +: 16] = rand_value(p_max[k]);
      send_word(d);
    end
    drop_valid();
  endtask

  task automatic random_config();
    logic [14:0] mx;
    reg_write(REG_MODE, $urandom);
    for (int k = 0; k < 4; k++) begin
      case ($urandom_range(4))
        0: mx = 15'd1;
        1: mx = 15'h7fff;
        2: mx = 15'($urandom);
        default: mx = 15'($urandom_range(1, 1000));
      endcase
      reg_write(reg_idx_t'(k + 1), {$urandom} & 32'hffff_8000 | mx);
    end
  endtask

  initial begin
    p_hsb = 0;
    for (int k = 0; k < 4; k++) p_max[k] = 15'd255;
    repeat (8) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, both modes, every hue third, zero maximum
    for (int m = 0; m < 2; m++) begin
      reg_write(REG_MODE, m);
      send_word({16'h8000, 16'h8000, 16'h8000, 16'h8000});
      send_word({16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff});
      send_word({16'd255, 16'd255, 16'd255, 16'd0});
      send_word({16'd128, 16'd200, 16'd255, 16'd50});
      send_word({16'd200, 16'd255, 16'd255, 16'd170});
      send_word({16'd100, 16'd0, 16'd255, 16'd85});
      send_word({16'd10, 16'd255, 16'd128, 16'd84});
      send_word({16'd128, 16'd128, 16'd128, 16'd171});
      drop_valid();
      drain();
    end
    reg_write(REG_MAX_FIRST, 32'd0);
    reg_write(REG_MAX_SECOND, 32'hffff_ffff);
    reg_write(REG_MAX_THIRD, 32'd1);
    reg_write(REG_MAX_OPACITY, 32'h7fff);
    send_word({16'd1, 16'd20000, 16'd1, 16'd3});
    send_word({16'hffff, 16'd32767, 16'd0, 16'd32767});
    drop_valid();
    drain();

    // random phases: idle settings cycle, config changes between phases
    for (int ph = 0; ph < 16; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
        default: begin send_idle_pct = 16; recv_stall_pct = 16; end
      endcase
      random_config();
      random_batch(60);
      // sender holds off until every word is back, then resumes
      drain();
      random_batch(60);
      drain();
    end

    if (board.errors == 0 && board.pending_rgba.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
